/* rtl/lzss_window_decompressor_top_assert.svh */
// assertion macros for the lzss window decompressor
// used by lzss_window_decompressor_top; expects clk and rst_n in scope
`ifndef LZSS_WINDOW_DECOMPRESSOR_TOP_ASSERT_SVH
`define LZSS_WINDOW_DECOMPRESSOR_TOP_ASSERT_SVH

// same-cycle implication, checked out of reset
`define LZSS_WD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lzss decompressor check failed");

// next-cycle implication, checked out of reset
`define LZSS_WD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lzss decompressor check failed");

`endif

/* rtl/lzss_wd_pkg.sv */
// shared constants and types for the lzss window decompressor
// no dependencies
package lzss_wd_pkg;

  localparam int WINDOW_BYTES_DEF = 4096;
  localparam int COUNT_W          = 32;
  localparam int LEN_W            = 5;
  localparam int MIN_MATCH        = 3;
  localparam int MAX_MATCH        = 18;
  localparam int ITEMS_PER_FLAG   = 8;

  typedef logic [7:0]         data_t;
  typedef logic [COUNT_W-1:0] count_t;

  typedef enum logic [4:0] {
    S_CLEAR  = 5'b00001,
    S_IDLE   = 5'b00010,
    S_STATUS = 5'b00100,
    S_READ   = 5'b01000,
    S_EMIT   = 5'b10000
  } state_t;

endpackage

/* rtl/lzss_wd_if.sv */
// valid/ready channel interfaces for the compressed input and the byte output
// depends on lzss_wd_pkg
interface lzss_wd_in_if;
  import lzss_wd_pkg::*;
  logic  valid;
  logic  ready;
  data_t in_byte;
  logic  in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface lzss_wd_out_if;
  import lzss_wd_pkg::*;
  logic  valid;
  logic  ready;
  data_t out_byte;
  logic  byte_valid;
  logic  run_last;
  logic  finished;
  logic  stream_error;

  modport source (output valid, output out_byte, output byte_valid, output run_last,
                  output finished, output stream_error, input ready);
  modport sink   (input valid, input out_byte, input byte_valid, input run_last,
                  input finished, input stream_error, output ready);
endinterface

/* rtl/lzss_window_decompressor_top.sv */
// lzss decompressor, 4 KiB window, 12-bit offsets, match lengths 3 to 18
// a literal is held in lit_r; the emit state moves it into the output register once the slot is free
// only the idle state takes input bytes, so no new byte is taken until the current request's results are out
// each copied byte takes a window read state and then a write/emit state on the ram
// reset (rst_n low, synchronous) clears control, then a pass zeroes every window address
// the input is not ready during that pass; cfg writes are taken in any state out of reset
`include "lzss_window_decompressor_top_assert.svh"

module lzss_window_decompressor_top #(
  parameter int WINDOW_BYTES = lzss_wd_pkg::WINDOW_BYTES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  lzss_wd_in_if.sink                  in_ch,
  lzss_wd_out_if.source               out_ch,
  input  logic                        cfg_wr_en,
  input  lzss_wd_pkg::count_t         cfg_wr_data
);
  import lzss_wd_pkg::*;

  localparam int AW = $clog2(WINDOW_BYTES);
  localparam logic [AW-1:0] WP_RESET  = AW'(WINDOW_BYTES - MAX_MATCH);
  localparam logic [AW-1:0] ADDR_LAST = AW'(WINDOW_BYTES - 1);

  // history window: one write port, one registered read port
  data_t window_mem [WINDOW_BYTES];

  state_t          state_r, state_nxt;
  logic [AW-1:0]   clr_addr_r, clr_addr_nxt;   // clearing pass address
  logic [AW-1:0]   wp_r, wp_nxt;               // window write pointer
  logic [AW-1:0]   src_r, src_nxt;             // copy source pointer
  logic [LEN_W-1:0] cnt_r, cnt_nxt;            // bytes left in this request
  data_t           flags_r, flags_nxt;
  logic [3:0]      items_r, items_nxt;         // items left in flag group
  logic            exp2_r, exp2_nxt;           // waiting on second pair byte
  data_t           first_r, first_nxt;
  count_t          bp_r, bp_nxt;               // bytes produced
  count_t          size_r, size_nxt;           // configured output size
  logic            err_r, err_nxt;             // stream ended short, sticky
  data_t           lit_r, lit_nxt;
  logic            lit_sel_r, lit_sel_nxt;     // emit the literal, not read data
  logic            last_in_r, last_in_nxt;     // in_last of the current request
  logic            st_err_r, st_err_nxt;       // error flag of a status result
  data_t           rd_data_r;

  // output register
  logic            out_valid_r, out_valid_nxt;
  data_t           out_byte_r, out_byte_nxt;
  logic            out_bv_r, out_bv_nxt;
  logic            out_rl_r, out_rl_nxt;
  logic            out_fin_r, out_fin_nxt;
  logic            out_err_r, out_err_nxt;

  logic            slot_free;
  logic            in_ready;
  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  data_t           mem_wdata;
  logic            rd_en;
  count_t          bp_inc;
  logic            fin_inc;
  logic            done;
  logic            short_end;
  data_t           emit_byte;

  assign slot_free = !out_valid_r || out_ch.ready;
  assign bp_inc    = bp_r + count_t'(1);
  assign fin_inc   = (bp_inc >= size_r);
  assign done      = (cnt_r == LEN_W'(1)) || fin_inc;
  assign short_end = last_in_r && !fin_inc && done;
  assign emit_byte = lit_sel_r ? lit_r : rd_data_r;

  always_comb begin
    state_nxt     = state_r;
    clr_addr_nxt  = clr_addr_r;
    wp_nxt        = wp_r;
    src_nxt       = src_r;
    cnt_nxt       = cnt_r;
    flags_nxt     = flags_r;
    items_nxt     = items_r;
    exp2_nxt      = exp2_r;
    first_nxt     = first_r;
    bp_nxt        = bp_r;
    size_nxt      = cfg_wr_en ? cfg_wr_data : size_r;
    err_nxt       = err_r;
    lit_nxt       = lit_r;
    lit_sel_nxt   = lit_sel_r;
    last_in_nxt   = last_in_r;
    st_err_nxt    = st_err_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_byte_nxt  = out_byte_r;
    out_bv_nxt    = out_bv_r;
    out_rl_nxt    = out_rl_r;
    out_fin_nxt   = out_fin_r;
    out_err_nxt   = out_err_r;
    mem_we        = 1'b0;
    mem_waddr     = wp_r;
    mem_wdata     = emit_byte;
    rd_en         = 1'b0;
    in_ready      = 1'b0;

    unique case (state_r)
      S_CLEAR: begin
        mem_we       = 1'b1;
        mem_waddr    = clr_addr_r;
        mem_wdata    = '0;
        clr_addr_nxt = clr_addr_r + AW'(1);
        if (clr_addr_r == ADDR_LAST) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_ch.valid) begin
          last_in_nxt = in_ch.in_last;
          if (err_r) begin
            st_err_nxt = 1'b1;
            state_nxt  = S_STATUS;
          end else if (bp_r >= size_r) begin
            // already finished: answer with a status result
            st_err_nxt = 1'b0;
            state_nxt  = S_STATUS;
          end else if (items_r == 4'd0) begin
            flags_nxt = in_ch.in_byte;
            items_nxt = 4'(ITEMS_PER_FLAG);
            if (in_ch.in_last) begin
              err_nxt    = 1'b1;
              st_err_nxt = 1'b1;
              state_nxt  = S_STATUS;
            end
          end else if (!exp2_r) begin
            if (flags_r[0]) begin
              lit_nxt     = in_ch.in_byte;
              lit_sel_nxt = 1'b1;
              cnt_nxt     = LEN_W'(1);
              flags_nxt   = flags_r >> 1;
              items_nxt   = items_r - 4'd1;
              state_nxt   = S_EMIT;
            end else begin
              first_nxt = in_ch.in_byte;
              exp2_nxt  = 1'b1;
              if (in_ch.in_last) begin
                err_nxt    = 1'b1;
                st_err_nxt = 1'b1;
                state_nxt  = S_STATUS;
              end
            end
          end else begin
            // second pair byte: high offset nibble and length
            src_nxt     = AW'({in_ch.in_byte[7:4], first_r});
            cnt_nxt     = LEN_W'(in_ch.in_byte[3:0]) + LEN_W'(MIN_MATCH);
            exp2_nxt    = 1'b0;
            lit_sel_nxt = 1'b0;
            flags_nxt   = flags_r >> 1;
            items_nxt   = items_r - 4'd1;
            state_nxt   = S_READ;
          end
        end
      end
      S_STATUS: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = '0;
          out_bv_nxt    = 1'b0;
          out_rl_nxt    = 1'b1;
          out_fin_nxt   = (bp_r >= size_r);
          out_err_nxt   = st_err_r;
          state_nxt     = S_IDLE;
        end
      end
      S_READ: begin
        // read issued after the previous write, so overlapping copies see it
        rd_en     = 1'b1;
        src_nxt   = src_r + AW'(1);
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (slot_free) begin
          mem_we        = 1'b1;
          wp_nxt        = wp_r + AW'(1);
          bp_nxt        = bp_inc;
          cnt_nxt       = cnt_r - LEN_W'(1);
          out_valid_nxt = 1'b1;
          out_byte_nxt  = emit_byte;
          out_bv_nxt    = 1'b1;
          out_rl_nxt    = done;
          out_fin_nxt   = fin_inc;
          out_err_nxt   = short_end;
          if (short_end) begin
            err_nxt = 1'b1;
          end
          state_nxt = done ? S_IDLE : S_READ;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_addr_r  <= '0;
      wp_r        <= WP_RESET;
      cnt_r       <= '0;
      flags_r     <= '0;
      items_r     <= '0;
      exp2_r      <= 1'b0;
      first_r     <= '0;
      bp_r        <= '0;
      size_r      <= '0;
      err_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      wp_r        <= wp_nxt;
      cnt_r       <= cnt_nxt;
      flags_r     <= flags_nxt;
      items_r     <= items_nxt;
      exp2_r      <= exp2_nxt;
      first_r     <= first_nxt;
      bp_r        <= bp_nxt;
      size_r      <= size_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    src_r      <= src_nxt;
    lit_r      <= lit_nxt;
    lit_sel_r  <= lit_sel_nxt;
    last_in_r  <= last_in_nxt;
    st_err_r   <= st_err_nxt;
    out_byte_r <= out_byte_nxt;
    out_bv_r   <= out_bv_nxt;
    out_rl_r   <= out_rl_nxt;
    out_fin_r  <= out_fin_nxt;
    out_err_r  <= out_err_nxt;
  end

  // window ram
  always_ff @(posedge clk) begin
    if (mem_we) begin
      window_mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rd_data_r <= window_mem[src_r];
    end
  end

  assign in_ch.ready         = in_ready;
  assign out_ch.valid        = out_valid_r;
  assign out_ch.out_byte     = out_byte_r;
  assign out_ch.byte_valid   = out_bv_r;
  assign out_ch.run_last     = out_rl_r;
  assign out_ch.finished     = out_fin_r;
  assign out_ch.stream_error = out_err_r;

  // a ready emit step always presents a result next cycle
  `LZSS_WD_ASSERT_NEXT(a_emit_loads_out, state_r == S_EMIT && slot_free, out_ch.valid)
  // the copy count never runs dry while emitting
  `LZSS_WD_ASSERT_NOW(a_emit_count_live, state_r == S_EMIT, cnt_r != '0)
  // an error is only flagged on the last result of a request
  `LZSS_WD_ASSERT_NOW(a_err_on_last, out_ch.valid && out_ch.stream_error, out_ch.run_last)
  // no request is taken while the window is being cleared
  `LZSS_WD_ASSERT_NOW(a_no_take_in_clear, state_r == S_CLEAR, !in_ch.ready)

endmodule
